// ----- hw/rtl/ternary_block_dot_product_unit_macros.svh -----
// Assertion macros shared by the RTL files of the ternary block dot product unit.
`ifndef TERNARY_BLOCK_DOT_PRODUCT_UNIT_MACROS_SVH
`define TERNARY_BLOCK_DOT_PRODUCT_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TBDP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define TBDP_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/tbdp_pkg.sv -----
package tbdp_pkg;

   // Field widths
   localparam int WEIGHT_W    = 8;
   localparam int ACT_W       = 8;
   localparam int SCALE_W     = 16;
   localparam int ROW_VALUE_W = 48;
   localparam int ROW_INDEX_W = 16;

   // Block geometry: 256 weights, four per byte
   localparam int BYTES_PER_BLOCK = 64;
   localparam int POS_W           = 6;
   localparam int BLOCK_SUM_W     = 17;
   localparam int ACC_W           = 64;
   localparam int FIX_W           = 32;

   // Fixed point format of scales and results
   localparam int FRACTION_BITS = 24;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMBINED_SCALE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_ROW      = 1'd1;

   // Ternary codes, decoded as code minus one
   localparam logic [1:0] CODE_NEG1 = 2'd0;
   localparam logic [1:0] CODE_ZERO = 2'd1;
   localparam logic [1:0] CODE_POS1 = 2'd2;
   localparam logic [1:0] CODE_POS2 = 2'd3;

   // fp16 exponent value for infinity and NaN
   localparam logic [4:0] HALF_EXP_SPECIAL = 5'd31;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLK_MUL,
      ST_BLK_ADD,
      ST_ROW_ABS,
      ST_ROW_MUL_LO,
      ST_ROW_MUL_HI,
      ST_ROW_SUM,
      ST_ROW_RND,
      ST_ROW_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MUL_BLK,
      MUL_LO,
      MUL_HI
   } mul_sel_type;

   typedef struct packed {
      logic        accept;
      logic        acc_add;
      logic        abs_load;
      logic        prod_init;
      logic        prod_add;
      logic        round_load;
      logic        emit_load;
      mul_sel_type mul_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic blk_end;
   } ctrl_status_type;

endpackage

// ----- hw/rtl/tbdp_req_if.sv -----
interface tbdp_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        weight_byte;
   logic signed [7:0] act_0;
   logic signed [7:0] act_1;
   logic signed [7:0] act_2;
   logic signed [7:0] act_3;
   logic [15:0]       block_scale;
   logic              last_of_row;

   modport source (
      output valid, weight_byte, act_0, act_1, act_2, act_3, block_scale, last_of_row,
      input  ready
   );

   modport sink (
      input  valid, weight_byte, act_0, act_1, act_2, act_3, block_scale, last_of_row,
      output ready
   );
endinterface

// ----- hw/rtl/tbdp_rsp_if.sv -----
interface tbdp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] row_value;
   logic [15:0]        row_index;

   modport source (
      output valid, row_value, row_index,
      input  ready
   );

   modport sink (
      input  valid, row_value, row_index,
      output ready
   );
endinterface

// ----- hw/rtl/tbdp_ctrl.sv -----
module tbdp_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_last,
   output logic                       req_ready,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   input  tbdp_pkg::ctrl_status_type  status,
   output tbdp_pkg::ctrl_cmd_type     cmd
);
   import tbdp_pkg::*;
   `include "ternary_block_dot_product_unit_macros.svh"

   state_type state_ff;
   state_type state_in;
   logic      last_ff;
   logic      last_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_last || status.blk_end)) state_in = ST_BLK_MUL;
         end
         ST_BLK_MUL:    state_in = ST_BLK_ADD;
         ST_BLK_ADD:    state_in = last_ff ? ST_ROW_ABS : ST_IDLE;
         ST_ROW_ABS:    state_in = ST_ROW_MUL_LO;
         ST_ROW_MUL_LO: state_in = ST_ROW_MUL_HI;
         ST_ROW_MUL_HI: state_in = ST_ROW_SUM;
         ST_ROW_SUM:    state_in = ST_ROW_RND;
         ST_ROW_RND:    state_in = ST_ROW_EMIT;
         ST_ROW_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mul_sel   = MUL_BLK;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = accept;
         end
         ST_BLK_MUL:    cmd.mul_sel = MUL_BLK;
         ST_BLK_ADD:    cmd.acc_add = 1'b1;
         ST_ROW_ABS:    cmd.abs_load = 1'b1;
         ST_ROW_MUL_LO: cmd.mul_sel = MUL_LO;
         ST_ROW_MUL_HI: begin
            cmd.mul_sel   = MUL_HI;
            cmd.prod_init = 1'b1;
         end
         ST_ROW_SUM:    cmd.prod_add = 1'b1;
         ST_ROW_RND:    cmd.round_load = 1'b1;
         ST_ROW_EMIT:   cmd.emit_load = out_free;
         default:       cmd = '0;
      endcase
   end

   // Row end mark of the item in flight, output valid
   always_comb begin
      last_in      = accept ? req_last : last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TBDP_ASSERT(a_no_overwrite, clock, reset, cmd.emit_load |-> (!rsp_valid_ff || rsp_ready), "result overwritten")
   `TBDP_ASSERT_NEXT(a_row_end_busy, clock, reset, accept && req_last, !req_ready, "item taken during row end")
   `TBDP_ASSERT_NEXT(a_mul_order, clock, reset, state_ff == ST_ROW_MUL_LO, state_ff == ST_ROW_MUL_HI, "partial products out of order")
   `TBDP_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_ROW_EMIT), "result without row end")

endmodule

// ----- hw/rtl/tbdp_datapath.sv -----
module tbdp_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tbdp_pkg::ctrl_cmd_type                 cmd,
   output tbdp_pkg::ctrl_status_type              status,
   input  logic [tbdp_pkg::WEIGHT_W-1:0]          weight_byte,
   input  logic signed [tbdp_pkg::ACT_W-1:0]      act_0,
   input  logic signed [tbdp_pkg::ACT_W-1:0]      act_1,
   input  logic signed [tbdp_pkg::ACT_W-1:0]      act_2,
   input  logic signed [tbdp_pkg::ACT_W-1:0]      act_3,
   input  logic [tbdp_pkg::SCALE_W-1:0]           block_scale,
   input  logic                                   last_of_row,
   input  logic                                   csr_we,
   input  logic [tbdp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tbdp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic signed [tbdp_pkg::ROW_VALUE_W-1:0] row_value,
   output logic [tbdp_pkg::ROW_INDEX_W-1:0]       row_index
);
   import tbdp_pkg::*;

   localparam int LSH = (FRACTION_BITS >= 24) ? FRACTION_BITS - 24 : 0;
   localparam int RSH = (FRACTION_BITS < 24) ? 24 - FRACTION_BITS : 0;
   localparam logic [47:0] HALF_RND = (RSH > 0) ? (48'd1 << (RSH - 1)) : 48'd0;
   localparam logic [96:0] ROW_RND  = 97'd1 << (FRACTION_BITS - 1);
   localparam logic [96:0] LIM_POS  = (97'd1 << (ROW_VALUE_W - 1)) - 97'd1;
   localparam logic [96:0] LIM_NEG  = 97'd1 << (ROW_VALUE_W - 1);
   localparam logic [47:0] FIX_MAX  = 48'h0000_7FFF_FFFF;
   localparam logic [47:0] FIX_MIN  = 48'h0000_8000_0000;

   // Architectural state
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic signed [BLOCK_SUM_W-1:0] block_sum_ff, block_sum_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [ROW_INDEX_W-1:0]        row_cnt_ff, row_cnt_in;
   logic signed [FIX_W-1:0]       cscale_ff, cscale_in;

   // Working registers
   logic signed [FIX_W-1:0]       scale_fix_ff;
   logic signed [63:0]            mul_ff;
   logic [ACC_W-1:0]              mag_a_ff;
   logic [FIX_W-1:0]              mag_c_ff;
   logic                          neg_ff;
   logic [95:0]                   prod_ff;
   logic [ROW_VALUE_W-1:0]        mag_ff;
   logic signed [ROW_VALUE_W-1:0] row_value_ff;
   logic [ROW_INDEX_W-1:0]        row_index_ff;

   logic signed [ACT_W-1:0]       acts [4];
   logic signed [9:0]             terms [4];
   logic signed [10:0]            byte_sum;
   logic signed [FIX_W-1:0]       scale_fix_in;
   logic signed [32:0]            op_a, op_b;
   logic signed [65:0]            mul_full;
   logic signed [ACC_W:0]         acc_sum;
   logic signed [ACC_W-1:0]       acc_sat;
   logic [96:0]                   rnd_sum, rnd_shift, lim;
   logic [ROW_VALUE_W-1:0]        mag_in;

   // fp16 conversion signals
   logic                          h_neg;
   logic [4:0]                    h_exp;
   logic [10:0]                   h_man;
   logic [4:0]                    h_sh;
   logic [39:0]                   h_t;
   logic [47:0]                   h_mag;

   assign acts[0] = act_0;
   assign acts[1] = act_1;
   assign acts[2] = act_2;
   assign acts[3] = act_3;

   assign status.blk_end = (pos_ff == POS_W'(BYTES_PER_BLOCK - 1));
   assign row_value      = row_value_ff;
   assign row_index      = row_index_ff;

   // Ternary products of one byte
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         case (weight_byte[2*k +: 2])
            CODE_NEG1: terms[k] = -10'(acts[k]);
            CODE_ZERO: terms[k] = '0;
            CODE_POS1: terms[k] = 10'(acts[k]);
            CODE_POS2: terms[k] = 10'(acts[k]) <<< 1;
            default:   terms[k] = '0;
         endcase
      end
      byte_sum = 11'(terms[0]) + 11'(terms[1]) + 11'(terms[2]) + 11'(terms[3]);
   end

   // fp16 scale to signed Q format, rounded half away, saturated, NaN to zero
   always_comb begin
      h_neg = block_scale[15];
      h_exp = block_scale[14:10];
      h_man = (h_exp == 5'd0) ? {1'b0, block_scale[9:0]} : {1'b1, block_scale[9:0]};
      h_sh  = (h_exp == 5'd0) ? 5'd0 : h_exp - 5'd1;
      h_t   = 40'(h_man) << h_sh;
      h_mag = ((48'(h_t) + HALF_RND) >> RSH) << LSH;
      if (h_exp == HALF_EXP_SPECIAL) begin
         if (block_scale[9:0] != 10'd0) begin
            scale_fix_in = '0;
         end else begin
            scale_fix_in = h_neg ? FIX_MIN[FIX_W-1:0] : FIX_MAX[FIX_W-1:0];
         end
      end else if (h_neg) begin
         scale_fix_in = (h_mag > FIX_MIN) ? FIX_MIN[FIX_W-1:0] : -h_mag[FIX_W-1:0];
      end else begin
         scale_fix_in = (h_mag > FIX_MAX) ? FIX_MAX[FIX_W-1:0] : h_mag[FIX_W-1:0];
      end
   end

   // Shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_LO: begin
            op_a = {1'b0, mag_a_ff[31:0]};
            op_b = {1'b0, mag_c_ff};
         end
         MUL_HI: begin
            op_a = {1'b0, mag_a_ff[63:32]};
            op_b = {1'b0, mag_c_ff};
         end
         default: begin
            op_a = 33'(block_sum_ff);
            op_b = 33'(scale_fix_ff);
         end
      endcase
      mul_full = op_a * op_b;
   end

   // Saturating accumulator add
   always_comb begin
      acc_sum = 65'(acc_ff) + 65'(mul_ff);
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sat = acc_sum[ACC_W-1:0];
      end
   end

   // Row result rounding and saturation
   always_comb begin
      rnd_sum   = {1'b0, prod_ff} + ROW_RND;
      rnd_shift = rnd_sum >> FRACTION_BITS;
      lim       = neg_ff ? LIM_NEG : LIM_POS;
      mag_in    = (rnd_shift > lim) ? lim[ROW_VALUE_W-1:0] : rnd_shift[ROW_VALUE_W-1:0];
   end

   // Next values of the architectural state
   always_comb begin
      pos_in       = pos_ff;
      block_sum_in = block_sum_ff;
      acc_in       = acc_ff;
      row_cnt_in   = row_cnt_ff;
      cscale_in    = cscale_ff;
      if (cmd.accept) begin
         block_sum_in = block_sum_ff + 17'(byte_sum);
         pos_in       = last_of_row ? '0 : pos_ff + POS_W'(1);
      end
      if (cmd.acc_add) begin
         acc_in       = acc_sat;
         block_sum_in = '0;
      end
      if (cmd.abs_load) begin
         acc_in = '0;
      end
      if (cmd.emit_load) begin
         row_cnt_in = row_cnt_ff + ROW_INDEX_W'(1);
      end
      if (csr_we) begin
         case (csr_index)
            CSR_COMBINED_SCALE: cscale_in  = csr_wdata[FIX_W-1:0];
            CSR_FIRST_ROW:      row_cnt_in = csr_wdata[ROW_INDEX_W-1:0];
            default:            cscale_in  = cscale_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         block_sum_ff <= '0;
         acc_ff       <= '0;
         row_cnt_ff   <= '0;
         cscale_ff    <= 32'sd1 <<< FRACTION_BITS;
      end else begin
         pos_ff       <= pos_in;
         block_sum_ff <= block_sum_in;
         acc_ff       <= acc_in;
         row_cnt_ff   <= row_cnt_in;
         cscale_ff    <= cscale_in;
      end
   end

   // Working registers, no reset
   always_ff @(posedge clock) begin
      mul_ff <= mul_full[63:0];
      if (cmd.accept) begin
         scale_fix_ff <= scale_fix_in;
      end
      if (cmd.abs_load) begin
         mag_a_ff <= acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
         mag_c_ff <= cscale_ff[FIX_W-1] ? -cscale_ff : cscale_ff;
         neg_ff   <= acc_ff[ACC_W-1] ^ cscale_ff[FIX_W-1];
      end
      if (cmd.prod_init) begin
         prod_ff <= {32'd0, mul_ff};
      end else if (cmd.prod_add) begin
         prod_ff <= prod_ff + {mul_ff, 32'd0};
      end
      if (cmd.round_load) begin
         mag_ff <= mag_in;
      end
      if (cmd.emit_load) begin
         row_value_ff <= neg_ff ? -mag_ff : mag_ff;
         row_index_ff <= row_cnt_ff;
      end
   end

endmodule

// ----- hw/rtl/ternary_block_dot_product_unit.sv -----
// Channel   Dir  Handshake     Payload
// req_bus   in   valid/ready   weight_byte, act_0..act_3, block_scale, last_of_row
// rsp_bus   out  valid/ready   row_value, row_index
// csr_*     in   csr_we        csr_index, csr_wdata (write only)
//
// An item inside a block is summed as it is taken; one that closes a block also
// runs block multiply and add. A row end then runs the 64x32 row scaling as two
// passes through the single shared 33x33 multiplier, then add, round and emit.
// Reset is synchronous; it clears block and row state and sets the combined scale to 1.0.
// The result register holds until taken; a row end waits in its emit step
// while it is full, and no item is accepted until that step completes.
module ternary_block_dot_product_unit (
   input  logic                                clock,
   input  logic                                reset,
   tbdp_req_if.sink                            req_bus,
   tbdp_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [tbdp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbdp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tbdp_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // Sequencer
   tbdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_of_row),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and state
   tbdp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .weight_byte (req_bus.weight_byte),
      .act_0       (req_bus.act_0),
      .act_1       (req_bus.act_1),
      .act_2       (req_bus.act_2),
      .act_3       (req_bus.act_3),
      .block_scale (req_bus.block_scale),
      .last_of_row (req_bus.last_of_row),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .row_value   (rsp_bus.row_value),
      .row_index   (rsp_bus.row_index)
   );

endmodule
